// File: rtl/ppt_pkg.sv
// Package for the process priority table: op and status codes, FSM states,
// table entry and cell control types. No dependencies.
package ppt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam int PID_W = 16;
  localparam int PRIO_W = 16;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;
  localparam int IDX_MAX_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOWEST  = 3'd3;
  localparam logic [OP_W-1:0] OP_HIGHEST = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PULL
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_ROTATE,
    CELL_PULL,
    CELL_CLEAR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic [IDX_MAX_W-1:0]   idx;
  } cell_ctrl_t;

  typedef struct packed {
    logic                     valid;
    logic [PID_W-1:0]         pid;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

endpackage

// File: rtl/ppt_cell.sv
// One slot of the table row: holds an entry and takes its neighbour's entry
// on push, rotate or pull. Depends on ppt_pkg.
module ppt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ppt_pkg::cell_ctrl_t ctrl,
  input  ppt_pkg::entry_t     from_left,
  input  ppt_pkg::entry_t     from_right,
  output ppt_pkg::entry_t     entry_q
);

  localparam int IdxMaxW = ppt_pkg::IDX_MAX_W;
  localparam logic [IdxMaxW-1:0] MyIdx = IdxMaxW'(CELL_INDEX);

  logic take_left;
  logic take_right;

  logic                              slot_valid;
  logic [ppt_pkg::PID_W-1:0]         slot_pid;
  logic signed [ppt_pkg::PRIO_W-1:0] slot_prio;

  assign entry_q = '{valid: slot_valid, pid: slot_pid, prio: slot_prio};

  always_comb begin
    take_left  = 1'b0;
    take_right = 1'b0;
    case (ctrl.cmd)
      ppt_pkg::CELL_PUSH:   take_left  = 1'b1;
      ppt_pkg::CELL_ROTATE: take_right = 1'b1;
      ppt_pkg::CELL_PULL:   take_right = (MyIdx >= ctrl.idx);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (ctrl.cmd == ppt_pkg::CELL_CLEAR) begin
      slot_valid <= 1'b0;
    end else if (take_left) begin
      slot_valid <= from_left.valid;
    end else if (take_right) begin
      slot_valid <= from_right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_left) begin
      slot_pid  <= from_left.pid;
      slot_prio <= from_left.prio;
    end else if (take_right) begin
      slot_pid  <= from_right.pid;
      slot_prio <= from_right.prio;
    end
  end

endmodule

// File: rtl/process_priority_table.sv
// Top level of the process priority table: control FSM, scan accumulator
// and the row of ppt_cell slots. Depends on ppt_pkg and ppt_cell.
//
// channel   direction  handshake             payload
// command   in         start && !busy        op, key_pid, key_priority
// result    out        done (one cycle)      status, match_pid, match_priority, count
//
// Insert, clear, unused ops and refused ops finish in the idle state; the result shows
// on the next cycle and a new command may be taken at once.
// Find, remove and (on a non-empty table) lowest and highest rotate the row through
// slot 0 once in the scan state, followed by the pull state for a successful remove.
// Reset (rst, synchronous) empties the table at once.
// The receiver cannot stall; each result is shown for one cycle only.
module process_priority_table #(
  parameter int TABLE_DEPTH = ppt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ppt_pkg::OP_W-1:0]            op,
  input  logic [ppt_pkg::PID_W-1:0]           key_pid,
  input  logic signed [ppt_pkg::PRIO_W-1:0]   key_priority,
  output logic                                done,
  output logic [ppt_pkg::STATUS_W-1:0]        status,
  output logic [ppt_pkg::PID_W-1:0]           match_pid,
  output logic signed [ppt_pkg::PRIO_W-1:0]   match_priority,
  output logic [ppt_pkg::COUNT_W-1:0]         count
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int IdxMaxW = ppt_pkg::IDX_MAX_W;
  localparam int CountW = ppt_pkg::COUNT_W;

  ppt_pkg::state_t     state, state_next;
  ppt_pkg::cell_ctrl_t cell_ctrl;
  ppt_pkg::entry_t     cell_q [TABLE_DEPTH];
  ppt_pkg::entry_t     key_entry;
  ppt_pkg::entry_t     tail_in;
  ppt_pkg::entry_t     head;
  logic [TABLE_DEPTH-1:0] valid_vec;

  logic [CntW-1:0] entry_count, entry_count_next;
  logic [IdxW-1:0] pos, pos_next;
  logic [IdxW-1:0] best_idx, best_idx_next;
  logic            found, found_next;
  logic [ppt_pkg::PID_W-1:0]         best_pid, best_pid_next;
  logic signed [ppt_pkg::PRIO_W-1:0] best_prio, best_prio_next;
  logic [ppt_pkg::OP_W-1:0]          scan_op;
  logic [ppt_pkg::PID_W-1:0]         scan_pid;

  logic                                done_next;
  logic [ppt_pkg::STATUS_W-1:0]        status_next;
  logic [ppt_pkg::PID_W-1:0]           match_pid_next;
  logic signed [ppt_pkg::PRIO_W-1:0]   match_priority_next;
  logic [CntW+CountW-1:0]              count_wide;

  logic accept, is_lookup, hit, better, take, last;

  assign accept    = start && !busy;
  assign head      = cell_q[0];
  assign key_entry = '{valid: 1'b1, pid: key_pid, prio: key_priority};
  assign tail_in   = '{valid: (cell_ctrl.cmd == ppt_pkg::CELL_ROTATE) && cell_q[0].valid,
                       pid: cell_q[0].pid, prio: cell_q[0].prio};

  assign is_lookup = (scan_op == ppt_pkg::OP_FIND) || (scan_op == ppt_pkg::OP_REMOVE);
  assign hit       = head.valid && (head.pid == scan_pid);
  assign better    = (scan_op == ppt_pkg::OP_HIGHEST) ? (head.prio > best_prio)
                                                      : (head.prio < best_prio);
  assign take      = head.valid && (is_lookup ? (!found && hit) : (!found || better));
  assign last      = (pos == IdxW'(TABLE_DEPTH - 1));
  assign count_wide = (CntW + CountW)'(entry_count_next);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      ppt_cell #(.CELL_INDEX(gi)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl),
        .from_left  ((gi == 0) ? key_entry : cell_q[(gi == 0) ? 0 : gi - 1]),
        .from_right ((gi == TABLE_DEPTH - 1) ? tail_in
                                             : cell_q[(gi == TABLE_DEPTH - 1) ? gi : gi + 1]),
        .entry_q    (cell_q[gi])
      );
      assign valid_vec[gi] = cell_q[gi].valid;
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ppt_pkg::S_IDLE: begin
        if (accept) begin
          if ((op == ppt_pkg::OP_FIND) || (op == ppt_pkg::OP_REMOVE)) begin
            state_next = ppt_pkg::S_SCAN;
          end else if (((op == ppt_pkg::OP_LOWEST) || (op == ppt_pkg::OP_HIGHEST))
                       && (entry_count != '0)) begin
            state_next = ppt_pkg::S_SCAN;
          end
        end
      end
      ppt_pkg::S_SCAN: begin
        if (last) begin
          if ((scan_op == ppt_pkg::OP_REMOVE) && found_next) begin
            state_next = ppt_pkg::S_PULL;
          end else begin
            state_next = ppt_pkg::S_IDLE;
          end
        end
      end
      ppt_pkg::S_PULL: state_next = ppt_pkg::S_IDLE;
      default: state_next = ppt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy                = (state != ppt_pkg::S_IDLE);
    cell_ctrl.cmd       = ppt_pkg::CELL_HOLD;
    cell_ctrl.idx       = IdxMaxW'(best_idx);
    entry_count_next    = entry_count;
    pos_next            = pos;
    found_next          = found;
    best_idx_next       = best_idx;
    best_pid_next       = best_pid;
    best_prio_next      = best_prio;
    done_next           = 1'b0;
    status_next         = ppt_pkg::ST_OK;
    match_pid_next      = '0;
    match_priority_next = '0;
    case (state)
      ppt_pkg::S_IDLE: begin
        if (accept) begin
          pos_next   = '0;
          found_next = 1'b0;
          case (op)
            ppt_pkg::OP_INSERT: begin
              done_next = 1'b1;
              if (entry_count == CntW'(TABLE_DEPTH)) begin
                status_next = ppt_pkg::ST_FULL;
              end else begin
                cell_ctrl.cmd       = ppt_pkg::CELL_PUSH;
                entry_count_next    = entry_count + CntW'(1);
                match_pid_next      = key_pid;
                match_priority_next = key_priority;
              end
            end
            ppt_pkg::OP_FIND, ppt_pkg::OP_REMOVE: ;
            ppt_pkg::OP_LOWEST, ppt_pkg::OP_HIGHEST: begin
              if (entry_count == '0) begin
                done_next   = 1'b1;
                status_next = ppt_pkg::ST_EMPTY;
              end
            end
            ppt_pkg::OP_CLEAR: begin
              cell_ctrl.cmd    = ppt_pkg::CELL_CLEAR;
              entry_count_next = '0;
              done_next        = 1'b1;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ppt_pkg::S_SCAN: begin
        cell_ctrl.cmd = ppt_pkg::CELL_ROTATE;
        pos_next      = pos + IdxW'(1);
        if (take) begin
          found_next     = 1'b1;
          best_idx_next  = pos;
          best_pid_next  = head.pid;
          best_prio_next = head.prio;
        end
        if (last) begin
          if (!found_next) begin
            done_next   = 1'b1;
            status_next = ppt_pkg::ST_NOT_FOUND;
          end else if (scan_op != ppt_pkg::OP_REMOVE) begin
            done_next           = 1'b1;
            match_pid_next      = best_pid_next;
            match_priority_next = best_prio_next;
          end
        end
      end
      ppt_pkg::S_PULL: begin
        cell_ctrl.cmd       = ppt_pkg::CELL_PULL;
        entry_count_next    = entry_count - CntW'(1);
        done_next           = 1'b1;
        match_pid_next      = best_pid;
        match_priority_next = best_prio;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ppt_pkg::S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
      found       <= 1'b0;
      pos         <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      done        <= done_next;
      found       <= found_next;
      pos         <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_op  <= op;
      scan_pid <= key_pid;
    end
    best_idx  <= best_idx_next;
    best_pid  <= best_pid_next;
    best_prio <= best_prio_next;
    if (done_next) begin
      status         <= status_next;
      match_pid      <= match_pid_next;
      match_priority <= match_priority_next;
      count          <= count_wide[CountW-1:0];
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(TABLE_DEPTH))
    else $error("entry count above depth");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    (state == ppt_pkg::S_IDLE) |-> ($countones(valid_vec) == int'(entry_count)))
    else $error("valid slots disagree with entry count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == ppt_pkg::OP_INSERT) && (entry_count == CntW'(TABLE_DEPTH)))
    |=> (done && (status == ppt_pkg::ST_FULL)))
    else $error("insert into full table not refused");

endmodule
